@@ rtl/dq_pkg.sv @@
package dq_pkg;

  // Sizes fixed by the item fields
  localparam int DATA_W      = 32;
  localparam int FILL_W      = 8;
  localparam int DEPTH_DEF   = 128;
  // Depth of the command queue and of the result queue
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic              wr;
    logic              rd;
    status_t           status;
    logic [FILL_W-1:0] fill;
  } cmd_info_t;

  // Finished result item
  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic [FILL_W-1:0]        fill;
  } res_t;

endpackage

@@ rtl/dq_fifo.sv @@
module dq_fifo #(
  parameter int WIDTH  = 8,
  parameter int QDEPTH = dq_pkg::QUEUE_DEPTH,
  parameter int PW     = $clog2(QDEPTH),
  parameter int CW     = $clog2(QDEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty,
  output logic [CW-1:0]    count
);

  localparam logic [PW-1:0] LAST_P = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] FULL_C = CW'(QDEPTH);

  logic [WIDTH-1:0] slot_r [QDEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == FULL_C);
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

@@ rtl/dq_front.sv @@
module dq_front #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             acc,
  input  logic [1:0]                       req_type,
  input  logic signed [dq_pkg::DATA_W-1:0] push_value,
  output dq_pkg::cmd_info_t                cmd_info,
  output logic [AW-1:0]                    cmd_addr,
  output logic signed [dq_pkg::DATA_W-1:0] cmd_data
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] head_dec, head_inc;
  logic [SW-1:0] rear_sum, rear_pos;
  req_t          req;

  assign req      = req_t'(req_type);
  assign cmd_data = push_value;

  // Ring neighbours of the head
  assign head_dec = (head_r == '0) ? LAST_A : head_r - AW'(1);
  assign head_inc = (head_r == LAST_A) ? '0 : head_r + AW'(1);

  // Rear slot: next free one for a push, last held one for a pop
  assign rear_sum = SW'(head_r) + SW'(count_r)
                  - ((req == REQ_POP_REAR) ? SW'(1) : SW'(0));
  assign rear_pos = (rear_sum >= DEPTH_S) ? rear_sum - DEPTH_S : rear_sum;

  // Classify the request against the current occupancy
  always_comb begin
    head_nxt        = head_r;
    count_nxt       = count_r;
    cmd_addr        = head_r;
    cmd_info.wr     = 1'b0;
    cmd_info.rd     = 1'b0;
    cmd_info.status = ST_OK;
    unique case (req)
      REQ_PUSH_FRONT: begin
        if (count_r == DEPTH_C) begin
          cmd_info.status = ST_FULL;
        end else begin
          head_nxt    = head_dec;
          cmd_addr    = head_dec;
          cmd_info.wr = 1'b1;
          count_nxt   = count_r + CW'(1);
        end
      end
      REQ_PUSH_REAR: begin
        if (count_r == DEPTH_C) begin
          cmd_info.status = ST_FULL;
        end else begin
          cmd_addr    = rear_pos[AW-1:0];
          cmd_info.wr = 1'b1;
          count_nxt   = count_r + CW'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (count_r == '0) begin
          cmd_info.status = ST_EMPTY;
        end else begin
          head_nxt    = head_inc;
          cmd_info.rd = 1'b1;
          count_nxt   = count_r - CW'(1);
        end
      end
      REQ_POP_REAR: begin
        if (count_r == '0) begin
          cmd_info.status = ST_EMPTY;
        end else begin
          cmd_addr    = rear_pos[AW-1:0];
          cmd_info.rd = 1'b1;
          count_nxt   = count_r - CW'(1);
        end
      end
      default: begin
        cmd_info.status = ST_OK;
      end
    endcase
    cmd_info.fill = FILL_W'(count_nxt);
  end

  // Head pointer and element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (acc) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/dq_back.sv @@
module dq_back #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  input  dq_pkg::cmd_info_t                cmd_info,
  input  logic [AW-1:0]                    cmd_addr,
  input  logic signed [dq_pkg::DATA_W-1:0] cmd_data,
  output logic                             cmd_pop,
  input  logic                             res_pop,
  output logic                             res_empty,
  output dq_pkg::res_t                     res
);
  import dq_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW  = $bits(res_t);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;
  logic                     s1_valid_r;
  cmd_info_t                s1_info_r;
  logic [QCW-1:0]           oq_cnt;
  logic                     room;
  res_t                     res_in;
  logic [RW-1:0]            res_out;

  // Issue only with a free result slot for every item in flight
  assign room    = ({1'b0, oq_cnt} + (QCW + 1)'(s1_valid_r)) < (QCW + 1)'(QUEUE_DEPTH);
  assign cmd_pop = cmd_valid && room;

  // Element store: one write or one read each cycle, read data registered
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd_info.wr) begin
      mem[cmd_addr] <= cmd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd_info.rd) begin
      rdata_r <= mem[cmd_addr];
    end
  end

  // Stage holding the item while its read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_info_r <= cmd_info;
    end
  end

  // Result assembly
  always_comb begin
    res_in.status = s1_info_r.status;
    res_in.value  = s1_info_r.rd ? rdata_r : '0;
    res_in.fill   = s1_info_r.fill;
  end

  // Result queue; the credit check above keeps it from overflowing
  dq_fifo #(
    .WIDTH  (RW),
    .QDEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s1_valid_r),
    .wr_data (res_in),
    .rd_en   (res_pop),
    .rd_data (res_out),
    .full    (),
    .empty   (res_empty),
    .count   (oq_cnt)
  );

  assign res = res_t'(res_out);

endmodule

@@ rtl/double_ended_queue_top.sv @@
// Double-ended queue of signed 32-bit values in a ring of DEPTH entries.
// Each item pushes at the front or rear or pops from either end, and gives
// one result with a status (ok, empty on pop, full on push), the popped
// value (zero otherwise) and the element count after the request, always in
// request order. Items are taken one per clock cycle, sustained, as long as
// results are popped; a result passes the command queue, the read stage
// and the result queue before it is visible. The front updates the head
// pointer and count in the cycle an item arrives, so the rate is set by
// that update and by the one-port element store, which does one write or
// one read per cycle. A four-entry command queue and a four-entry result
// queue sit between the parts; full rises once the result side stalls and
// both queues have filled. Never-written store entries are not reset.
module double_ended_queue_top #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       in_req_type,
  input  logic signed [dq_pkg::DATA_W-1:0] in_push_value,
  output logic                             empty,
  input  logic                             pop,
  output logic [1:0]                       out_status,
  output logic signed [dq_pkg::DATA_W-1:0] out_pop_value,
  output logic [dq_pkg::FILL_W-1:0]        out_fill_count
);
  import dq_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CMD_W = $bits(cmd_info_t) + AW + DATA_W;

  logic                     acc;
  cmd_info_t                f_info, b_info;
  logic [AW-1:0]            f_addr, b_addr;
  logic signed [DATA_W-1:0] f_data, b_data;
  logic [CMD_W-1:0]         cq_wdata, cq_rdata;
  logic                     cq_empty;
  logic                     cq_pop;
  res_t                     res;

  assign acc = push && !full;

  // Front: classify and update ring pointers
  dq_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .req_type   (in_req_type),
    .push_value (in_push_value),
    .cmd_info   (f_info),
    .cmd_addr   (f_addr),
    .cmd_data   (f_data)
  );

  // Command queue between front and back
  assign cq_wdata = {f_info, f_addr, f_data};

  dq_fifo #(
    .WIDTH  (CMD_W),
    .QDEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (acc),
    .wr_data (cq_wdata),
    .rd_en   (cq_pop),
    .rd_data (cq_rdata),
    .full    (full),
    .empty   (cq_empty),
    .count   ()
  );

  assign {b_info, b_addr, b_data} = cq_rdata;

  // Back: store access and result queue
  dq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cq_empty),
    .cmd_info  (b_info),
    .cmd_addr  (b_addr),
    .cmd_data  (b_data),
    .cmd_pop   (cq_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign out_status     = res.status;
  assign out_pop_value  = res.value;
  assign out_fill_count = res.fill;

endmodule
